// ===== design/sdv_pkg.sv =====
// package for the speculative draft verify unit
// holds payload structs, sizes and state encodings; no dependencies

package sdv_pkg;

  localparam int unsigned MaxList   = 64;
  localparam int unsigned MaxDrafts = 5;

  localparam int unsigned TokW  = 31;
  localparam int unsigned ProbW = 17;
  localparam int unsigned UniW  = 16;
  localparam int unsigned CfgW  = 7;

  localparam logic CfgDraftCount = 1'b0;
  localparam logic CfgListLength = 1'b1;

  typedef struct packed {
    logic [30:0] proposal_token;
    logic [16:0] proposal_prob;
    logic [30:0] target_token;
    logic [16:0] target_prob;
    logic [30:0] draft_id;
    logic [15:0] uniform;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  accepted;
    logic [30:0] chosen_token;
    logic        chosen_valid;
  } out_beat_t;

  typedef enum logic [3:0] {
    StLoad,
    StAccScan,
    StAccTest,
    StResOuter,
    StResInner,
    StResWrite,
    StDraw,
    StDrawTest,
    StOut
  } state_e;

endpackage

// ===== design/sdv_ram.sv =====
// generic single port write, single read port ram with registered read
// no dependencies

module sdv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/speculative_draft_verify_top_k_unit.sv =====
// top level of the speculative draft verify unit: loader, stores, sequencer
// depends on sdv_pkg and sdv_ram
//
// channel | dir | handshake          | payload
// in      | in  | in_valid_i/ready_o | in_data_i  (sdv_pkg::in_beat_t)
// out     | out | out_valid_o/ready_i| out_data_o (sdv_pkg::out_beat_t)
// cfg     | in  | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// a load beat is taken whenever the unit is in its load state; the beat with last starts the verify walk
// verify tests each position in turn; the residual matches tokens pairwise
// through one ram read port, and the draw first totals and then walks the masses
// one shared multiplier serves both the acceptance test and the draw
// reset clears the state, the load counters and the configuration only; stores are undefined until written
// the result register holds until taken; no new beat is taken meanwhile

module speculative_draft_verify_top_k_unit #(
  parameter int unsigned MaxList   = sdv_pkg::MaxList,
  parameter int unsigned MaxDrafts = sdv_pkg::MaxDrafts
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdv_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdv_pkg::out_beat_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [sdv_pkg::CfgW-1:0] cfg_data_i
);

  localparam int unsigned RW   = $clog2(MaxList) > 0 ? $clog2(MaxList) : 1;
  localparam int unsigned KW   = $clog2(MaxList + 1);
  localparam int unsigned PW   = $clog2(MaxDrafts + 1);
  localparam int unsigned PDep = MaxDrafts * MaxList;
  localparam int unsigned TDep = (MaxDrafts + 1) * MaxList;
  localparam int unsigned PAW  = $clog2(PDep);
  localparam int unsigned TAW  = $clog2(TDep);
  localparam int unsigned LPW  = $clog2(TDep + 1);
  localparam int unsigned SumW = sdv_pkg::ProbW + RW + 1;

  // configuration
  logic [PW-1:0] dcnt_q;
  logic [KW-1:0] klen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= PW'(1);
      klen_q <= KW'(MaxList);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sdv_pkg::CfgDraftCount) begin
        if (cfg_data_i[2:0] == 3'd0) dcnt_q <= PW'(1);
        else if (32'(cfg_data_i[2:0]) > MaxDrafts) dcnt_q <= PW'(MaxDrafts);
        else dcnt_q <= PW'(cfg_data_i[2:0]);
      end else begin
        if (cfg_data_i == 7'd0) klen_q <= KW'(1);
        else if (32'(cfg_data_i) > MaxList) klen_q <= KW'(MaxList);
        else klen_q <= KW'(cfg_data_i);
      end
    end
  end

  sdv_pkg::state_e st_q, st_d;

  // load position kept as (position, rank) counters
  logic [LPW-1:0] lpos_q, lpos_d;
  logic [PW-1:0]  lp_q, lp_d;
  logic [RW-1:0]  lr_q, lr_d;

  // sequencer registers
  logic [PW-1:0]  pos_q, pos_d;
  logic [KW-1:0]  r_q, r_d;
  logic [KW-1:0]  pr_q, pr_d;
  logic [sdv_pkg::ProbW-1:0] q_q, q_d, p_q, p_d, qt_q, qt_d;
  logic           hit_q, hit_d;
  logic [SumW-1:0] tot_q, tot_d, cum_q, cum_d;
  logic           fb_q, fb_d;
  logic [sdv_pkg::TokW-1:0] tok_q, tok_d;
  logic           vld_q, vld_d;
  logic [PW-1:0]  acc_q, acc_d;
  logic           ph_q, ph_d;   // draw phase: 0 sum, 1 pick

  // small register files (fixed depth; draft ids read in one place, uniforms in two)
  logic [sdv_pkg::TokW-1:0] draft_q [MaxDrafts];
  logic [sdv_pkg::UniW-1:0] uni_q   [MaxDrafts+1];

  // ram ports
  logic           pw_we, tw_we, rs_we;
  logic [PAW-1:0] pw_a, pr_a;
  logic [TAW-1:0] tw_a, tr_a;
  logic [RW-1:0]  rs_wa, rs_ra;
  logic [sdv_pkg::TokW-1:0]  ptok_rd, ttok_rd;
  logic [sdv_pkg::ProbW-1:0] pprob_rd, tprob_rd, res_rd, res_wd;

  logic in_fire;
  assign in_ready_o = (st_q == sdv_pkg::StLoad);
  assign in_fire    = in_valid_i && in_ready_o;

  logic load_ok;
  assign load_ok = 32'(lpos_q) < (32'(dcnt_q) + 1) * 32'(klen_q);

  assign pw_we = in_fire && load_ok && (lp_q < dcnt_q);
  assign tw_we = in_fire && load_ok;
  assign pw_a  = PAW'(32'(lp_q) * MaxList + 32'(lr_q));
  assign tw_a  = TAW'(32'(lp_q) * MaxList + 32'(lr_q));

  sdv_ram #(.Width(sdv_pkg::TokW), .Depth(PDep)) u_ptok (
    .clk_i, .we_i(pw_we), .waddr_i(pw_a), .wdata_i(in_data_i.proposal_token),
    .raddr_i(pr_a), .rdata_o(ptok_rd));
  sdv_ram #(.Width(sdv_pkg::ProbW), .Depth(PDep)) u_pprob (
    .clk_i, .we_i(pw_we), .waddr_i(pw_a), .wdata_i(in_data_i.proposal_prob),
    .raddr_i(pr_a), .rdata_o(pprob_rd));
  sdv_ram #(.Width(sdv_pkg::TokW), .Depth(TDep)) u_ttok (
    .clk_i, .we_i(tw_we), .waddr_i(tw_a), .wdata_i(in_data_i.target_token),
    .raddr_i(tr_a), .rdata_o(ttok_rd));
  sdv_ram #(.Width(sdv_pkg::ProbW), .Depth(TDep)) u_tprob (
    .clk_i, .we_i(tw_we), .waddr_i(tw_a), .wdata_i(in_data_i.target_prob),
    .raddr_i(tr_a), .rdata_o(tprob_rd));
  sdv_ram #(.Width(sdv_pkg::ProbW), .Depth(MaxList)) u_res (
    .clk_i, .we_i(rs_we), .waddr_i(rs_wa), .wdata_i(res_wd),
    .raddr_i(rs_ra), .rdata_o(res_rd));

  // draft and uniform capture at rank zero
  always_ff @(posedge clk_i) begin
    if (in_fire && load_ok && lr_q == '0) begin
      if (lp_q < dcnt_q) draft_q[lp_q] <= in_data_i.draft_id;
      uni_q[lp_q] <= in_data_i.uniform;
    end
  end

  logic [sdv_pkg::TokW-1:0] cur_draft;
  logic [sdv_pkg::UniW-1:0] cur_uni, bon_uni;
  assign cur_draft = draft_q[pos_q < PW'(MaxDrafts) ? pos_q : '0];
  assign cur_uni   = uni_q[pos_q];
  assign bon_uni   = uni_q[dcnt_q];

  // shared multiply unit
  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] mul_y;
  assign mul_y = 50'(mul_a) * 50'(mul_b);

  logic [RW-1:0] r_idx, pr_idx;
  assign r_idx  = r_q[RW-1:0];
  assign pr_idx = pr_q[RW-1:0];

  logic [PW-1:0] base_p;
  assign base_p = (st_q == sdv_pkg::StDraw || st_q == sdv_pkg::StDrawTest) &&
                  (acc_q == dcnt_q) ? dcnt_q : acc_q;

  logic [sdv_pkg::ProbW-1:0] mass;
  assign mass = fb_q ? tprob_rd : res_rd;

  always_comb begin
    st_d = st_q; lpos_d = lpos_q; lp_d = lp_q; lr_d = lr_q;
    pos_d = pos_q; r_d = r_q; pr_d = pr_q; q_d = q_q; p_d = p_q; qt_d = qt_q;
    hit_d = hit_q; tot_d = tot_q; cum_d = cum_q; fb_d = fb_q; tok_d = tok_q;
    vld_d = vld_q; acc_d = acc_q; ph_d = ph_q;
    pr_a = PAW'(32'(pos_q) * MaxList + 32'(r_idx));
    tr_a = TAW'(32'(pos_q) * MaxList + 32'(r_idx));
    rs_we = 1'b0; rs_wa = r_idx; res_wd = '0; rs_ra = r_idx;
    mul_a = '0; mul_b = '0;
    unique case (st_q)
      sdv_pkg::StLoad: begin
        if (in_fire) begin
          if (load_ok) begin
            lpos_d = lpos_q + LPW'(1);
            if (KW'(lr_q) + KW'(1) == klen_q) begin
              lr_d = '0; lp_d = lp_q + PW'(1);
            end else begin
              lr_d = lr_q + RW'(1);
            end
          end
          if (in_data_i.last) begin
            lpos_d = '0; lp_d = '0; lr_d = '0;
            pos_d = '0; acc_d = '0; r_d = '0; q_d = '0; p_d = '0;
            st_d = sdv_pkg::StAccScan;
          end
        end
      end
      // issue read of rank r, compare in the following cycle
      sdv_pkg::StAccScan: begin
        st_d = sdv_pkg::StAccTest;
      end
      sdv_pkg::StAccTest: begin
        if (ptok_rd == cur_draft) q_d = pprob_rd;
        if (ttok_rd == cur_draft) p_d = tprob_rd;
        if (r_q + KW'(1) == klen_q) begin
          mul_a = 33'(cur_uni); mul_b = q_d;
          if (q_d != '0 && (p_d >= q_d || mul_y < 50'({p_d, 16'd0}))) begin
            acc_d = acc_q + PW'(1);
            pos_d = pos_q + PW'(1);
            r_d = '0; q_d = '0; p_d = '0;
            if (acc_d == dcnt_q) begin
              fb_d = 1'b1; r_d = '0; tot_d = '0; cum_d = '0; ph_d = 1'b0;
              tok_d = '0; vld_d = 1'b0; st_d = sdv_pkg::StDraw;
            end else begin
              st_d = sdv_pkg::StAccScan;
            end
          end else begin
            r_d = '0; pr_d = '0; tot_d = '0; st_d = sdv_pkg::StResOuter;
          end
        end else begin
          r_d = r_q + KW'(1);
          st_d = sdv_pkg::StAccScan;
        end
      end
      // residual: for target rank r find first proposal rank with same token
      sdv_pkg::StResOuter: begin
        pr_a = PAW'(32'(acc_q) * MaxList + 32'(pr_idx));
        tr_a = TAW'(32'(acc_q) * MaxList + 32'(r_idx));
        if (pr_q == '0) begin
          hit_d = 1'b0; qt_d = '0;
        end
        st_d = sdv_pkg::StResInner;
      end
      sdv_pkg::StResInner: begin
        pr_a = PAW'(32'(acc_q) * MaxList + 32'(pr_idx));
        tr_a = TAW'(32'(acc_q) * MaxList + 32'(r_idx));
        if (!hit_q && ptok_rd == ttok_rd) begin
          hit_d = 1'b1; qt_d = pprob_rd;
        end
        if (pr_q + KW'(1) == klen_q) begin
          st_d = sdv_pkg::StResWrite;
        end else begin
          pr_d = pr_q + KW'(1);
          st_d = sdv_pkg::StResOuter;
        end
      end
      sdv_pkg::StResWrite: begin
        rs_we = 1'b1;
        res_wd = tprob_rd > qt_q ? tprob_rd - qt_q : '0;
        tot_d = tot_q + SumW'(res_wd);
        pr_d = '0;
        if (r_q + KW'(1) == klen_q) begin
          fb_d = (tot_d == '0); r_d = '0; tot_d = '0; cum_d = '0; ph_d = 1'b0;
          tok_d = '0; vld_d = 1'b0; st_d = sdv_pkg::StDraw;
        end else begin
          r_d = r_q + KW'(1);
          st_d = sdv_pkg::StResOuter;
        end
      end
      // draw: phase 0 totals masses, phase 1 walks cumulative mass
      sdv_pkg::StDraw: begin
        tr_a = TAW'(32'(base_p) * MaxList + 32'(r_idx));
        st_d = sdv_pkg::StDrawTest;
      end
      sdv_pkg::StDrawTest: begin
        tr_a = TAW'(32'(base_p) * MaxList + 32'(r_idx));
        st_d = sdv_pkg::StDraw;
        if (!ph_q) begin
          tot_d = tot_q + SumW'(mass);
          if (r_q + KW'(1) == klen_q) begin
            r_d = '0; ph_d = 1'b1;
          end else begin
            r_d = r_q + KW'(1);
          end
        end else begin
          mul_a = 33'(tot_q); mul_b = 17'(bon_uni);
          if (mass != '0) begin
            tok_d = ttok_rd; vld_d = 1'b1;
            cum_d = cum_q + SumW'(mass);
          end
          if ((mass != '0 && 50'({cum_d, 16'd0}) >= mul_y) ||
              r_q + KW'(1) == klen_q) begin
            st_d = sdv_pkg::StOut;
          end else begin
            r_d = r_q + KW'(1);
          end
        end
      end
      sdv_pkg::StOut: begin
        if (out_ready_i) st_d = sdv_pkg::StLoad;
      end
      default: st_d = sdv_pkg::StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sdv_pkg::StLoad;
      lpos_q <= '0; lp_q <= '0; lr_q <= '0;
    end else begin
      st_q <= st_d;
      lpos_q <= lpos_d; lp_q <= lp_d; lr_q <= lr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; r_q <= r_d; pr_q <= pr_d; q_q <= q_d; p_q <= p_d;
    qt_q <= qt_d; hit_q <= hit_d; tot_q <= tot_d; cum_q <= cum_d; fb_q <= fb_d;
    tok_q <= tok_d; vld_q <= vld_d; acc_q <= acc_d; ph_q <= ph_d;
  end

  assign out_valid_o = (st_q == sdv_pkg::StOut);
  assign out_data_o.accepted     = 3'(acc_q);
  assign out_data_o.chosen_token = tok_q;
  assign out_data_o.chosen_valid = vld_q;

endmodule

// ===== tb/tb_speculative_draft_verify_top_k_unit.sv =====
// testbench for speculative_draft_verify_top_k_unit: chain loads, verify results
// depends on sdv_pkg and the unit's rtl; self-contained, no files read
`timescale 1ns / 1ps

module tb_speculative_draft_verify_top_k_unit;

  localparam int unsigned MaxTok = 32'h7fff_ffff;
  localparam int unsigned One    = 65536;
  localparam int unsigned MaxL   = sdv_pkg::MaxList;
  localparam int unsigned MaxD   = sdv_pkg::MaxDrafts;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  sdv_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  sdv_pkg::out_beat_t out_data_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [6:0]         cfg_data_i;

  speculative_draft_verify_top_k_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock and timeout
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_speculative_draft_verify_top_k_unit: done, errors");
    $finish;
  end

  // shadow of the chain stores, configuration and written coverage
  int unsigned prop_tok [MaxD*MaxL];
  int unsigned prop_pr  [MaxD*MaxL];
  int unsigned tgt_tok  [(MaxD+1)*MaxL];
  int unsigned tgt_pr   [(MaxD+1)*MaxL];
  int unsigned draft_tok[MaxD];
  int unsigned uni_val  [MaxD+1];
  int unsigned resid    [MaxL];
  bit          wr_prop  [MaxD*MaxL];
  bit          wr_tgt   [(MaxD+1)*MaxL];
  bit          wr_draft [MaxD];
  bit          wr_uni   [MaxD+1];
  int unsigned load_pos;
  int unsigned n_drafts;
  int unsigned n_list;

  sdv_pkg::out_beat_t verdict_q[$];
  int          n_err;
  int          n_items;
  int          n_verdicts;
  int          n_accept_hist[MaxD+1];
  bit          quiet;

  // cumulative-mass draw over the target list or the residual
  task automatic draw_token(int unsigned base, bit use_tgt, int unsigned u,
                            output sdv_pkg::out_beat_t res);
    longint unsigned total, cum;
    int unsigned m;
    total = 0;
    cum = 0;
    res.chosen_token = '0;
    res.chosen_valid = 1'b0;
    for (int r = 0; r < n_list; r++) total += use_tgt ? tgt_pr[base+r] : resid[r];
    for (int r = 0; r < n_list; r++) begin
      m = use_tgt ? tgt_pr[base+r] : resid[r];
      if (m > 0) begin
        res.chosen_token = tgt_tok[base+r][30:0];
        res.chosen_valid = 1'b1;
        cum += m;
        if ((cum << 16) >= longint'(u) * total) break;
      end
    end
  endtask

  // store one beat and, on last, work out the verdict of the chain
  task automatic verify_chain(sdv_pkg::in_beat_t b, output bit has,
                              output sdv_pkg::out_beat_t res);
    int unsigned limit, p, rank, ti, q, pt, qt, m, accepted, base;
    longint unsigned total;
    limit = (n_drafts + 1) * n_list;
    res = '0;
    has = 1'b0;
    if (load_pos < limit) begin
      p = load_pos / n_list;
      rank = load_pos % n_list;
      ti = p * MaxL + rank;
      if (p < n_drafts) begin
        prop_tok[ti] = 32'(b.proposal_token);
        prop_pr[ti] = 32'(b.proposal_prob);
        wr_prop[ti] = 1'b1;
      end
      tgt_tok[ti] = 32'(b.target_token);
      tgt_pr[ti] = 32'(b.target_prob);
      wr_tgt[ti] = 1'b1;
      if (rank == 0) begin
        if (p < n_drafts) begin
          draft_tok[p] = 32'(b.draft_id);
          wr_draft[p] = 1'b1;
        end
        uni_val[p] = 32'(b.uniform);
        wr_uni[p] = 1'b1;
      end
      load_pos++;
    end
    if (!b.last) return;
    load_pos = 0;
    has = 1'b1;
    // in-order acceptance test
    accepted = 0;
    for (int d = 0; d < n_drafts; d++) begin
      base = d * MaxL;
      q = 0;
      pt = 0;
      for (int r = 0; r < n_list; r++) begin
        if (prop_tok[base+r] == draft_tok[d]) q = prop_pr[base+r];
        if (tgt_tok[base+r] == draft_tok[d]) pt = tgt_pr[base+r];
      end
      if (!(q > 0 && (pt >= q || longint'(uni_val[d]) * q < (longint'(pt) << 16)))) break;
      accepted++;
    end
    if (accepted == n_drafts) begin
      draw_token(n_drafts * MaxL, 1'b1, uni_val[n_drafts], res);
    end else begin
      // residual max(p-q,0), first matching proposal rank supplies q
      base = accepted * MaxL;
      total = 0;
      for (int r = 0; r < n_list; r++) begin
        qt = 0;
        for (int pr = 0; pr < n_list; pr++) begin
          if (prop_tok[base+pr] == tgt_tok[base+r]) begin
            qt = prop_pr[base+pr];
            break;
          end
        end
        m = tgt_pr[base+r];
        resid[r] = m > qt ? m - qt : 0;
        total += resid[r];
      end
      draw_token(base, total == 0, uni_val[n_drafts], res);
    end
    res.accepted = accepted[2:0];
  endtask

  // all entries a verify walk may read have been written at least once
  function automatic bit chain_covered();
    for (int d = 0; d <= n_drafts; d++) begin
      if (!wr_uni[d]) return 1'b0;
      if (d < n_drafts && !wr_draft[d]) return 1'b0;
      for (int r = 0; r < n_list; r++) begin
        if (!wr_tgt[d*MaxL+r]) return 1'b0;
        if (d < n_drafts && !wr_prop[d*MaxL+r]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // input driver: call at a falling edge, returns at a falling edge
  task automatic send_beat(sdv_pkg::in_beat_t b, bit typed, sdv_pkg::out_beat_t typed_res);
    bit has;
    sdv_pkg::out_beat_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    verify_chain(b, has, res);
    n_items++;
    if (has) verdict_q.insert(verdict_q.size(), typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sdv_pkg::CfgDraftCount) begin
      n_drafts = data[2:0] < 1 ? 1 : (data[2:0] > MaxD ? MaxD : data[2:0]);
    end else begin
      n_list = data < 1 ? 1 : (data > MaxL ? MaxL : data);
    end
  endtask

  // settle between phases: drain results, then let the unit go quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // random field helpers
  function automatic int unsigned rand_tok(int unsigned hint);
    case ($urandom_range(0, 9))
      0: return $urandom() & MaxTok;
      1, 2, 3: return hint;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic int unsigned rand_prob();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return One;
      2: return $urandom_range(0, 16);
      default: return $urandom_range(0, One);
    endcase
  endfunction

  function automatic int unsigned rand_uni();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // one chain load with random content; mostly well formed
  task automatic send_chain();
    int unsigned full, n, p, rank;
    int unsigned dtok[MaxD+1];
    sdv_pkg::in_beat_t b;
    sdv_pkg::out_beat_t none;
    none = '0;
    full = (n_drafts + 1) * n_list;
    case ($urandom_range(0, 9))
      0: n = full + $urandom_range(1, 3);
      1: n = chain_covered() ? $urandom_range(1, full) : full;
      default: n = full;
    endcase
    for (int d = 0; d <= MaxD; d++) dtok[d] = rand_tok($urandom_range(0, 7));
    for (int i = 0; i < n; i++) begin
      p = (i / n_list) % (n_drafts + 1);
      rank = i % n_list;
      b.proposal_token = 31'(rand_tok(dtok[p]));
      b.proposal_prob  = 17'(rand_prob());
      b.target_token   = 31'(rand_tok(dtok[p]));
      b.target_prob    = 17'(rand_prob());
      b.draft_id       = (rank == 0) ? 31'(dtok[p]) : 31'($urandom() & MaxTok);
      b.uniform        = 16'(rand_uni());
      b.last           = (i == n - 1);
      send_beat(b, 1'b0, none);
    end
  endtask

  // directed rows, K=1 and D=1 so a full load is one draft and one bonus entry
  typedef struct {
    sdv_pkg::in_beat_t  beat;
    bit                 typed;
    sdv_pkg::out_beat_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk(int unsigned pt, int unsigned pp, int unsigned tt,
                                  int unsigned tp, int unsigned dt, int unsigned u,
                                  bit lst, bit typed, int unsigned acc,
                                  int unsigned ctok, bit cval);
    dir_row_t row;
    row.beat = {pt[30:0], pp[16:0], tt[30:0], tp[16:0], dt[30:0], u[15:0], lst};
    row.typed = typed;
    row.res = {acc[2:0], ctok[30:0], cval};
    return row;
  endfunction

  task automatic add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // result sink with random stall bursts
  int stall_left;
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_ready_i <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result beat against the oldest expected verdict
  always @(posedge clk_i) begin
    sdv_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_verdicts++;
      if (verdict_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.accepted < 6) n_accept_hist[out_data_o.accepted]++;
        if (out_data_o.accepted !== want.accepted ||
            out_data_o.chosen_token !== want.chosen_token ||
            out_data_o.chosen_valid !== want.chosen_valid) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp acc=%0d tok=%0h v=%0b, got acc=%0d tok=%0h v=%0b",
                     want.accepted, want.chosen_token, want.chosen_valid,
                     out_data_o.accepted, out_data_o.chosen_token,
                     out_data_o.chosen_valid);
        end
      end
    end
  end

  // main sequence
  initial begin
    int unsigned wait_cnt;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b1;
    cfg_we_i = 1'b0;
    cfg_idx_i = sdv_pkg::CfgDraftCount;
    cfg_data_i = '0;
    n_err = 0;
    n_items = 0;
    n_verdicts = 0;
    quiet = 1'b0;
    load_pos = 0;
    n_drafts = 1;
    n_list = 64;
    for (int i = 0; i <= MaxD; i++) n_accept_hist[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: accept with bonus, reject, no mass, token extremes, long and short loads
    write_cfg(sdv_pkg::CfgDraftCount, 7'd1);
    write_cfg(sdv_pkg::CfgListLength, 7'd1);
    add_row(mk(5, One, 5, One, 5, 0, 0, 0, 0, 0, 0));
    add_row(mk(0, 0, 9, One, 0, 0, 1, 1, 1, 9, 1));
    add_row(mk(5, One, 7, One, 5, 0, 0, 0, 0, 0, 0));
    add_row(mk(0, 0, 9, One, 0, 0, 1, 1, 0, 7, 1));
    add_row(mk(5, 0, 5, 0, 5, 0, 0, 0, 0, 0, 0));
    add_row(mk(0, 0, 9, One, 0, 0, 1, 1, 0, 0, 0));
    add_row(mk(MaxTok, One, MaxTok, 1, MaxTok, 0, 0, 0, 0, 0, 0));
    add_row(mk(MaxTok, One, 0, 0, 0, 65535, 1, 1, 1, 0, 0));
    add_row(mk(MaxTok, One, MaxTok, 1, MaxTok, 65535, 0, 0, 0, 0, 0));
    add_row(mk(0, 0, 0, 0, 0, 0, 1, 1, 0, MaxTok, 1));
    add_row(mk(3, 100, 3, 200, 3, 1000, 0, 0, 0, 0, 0));
    add_row(mk(0, 0, 4, 500, 0, 30000, 0, 0, 0, 0, 0));
    add_row(mk(1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0));
    add_row(mk(2, 300, 2, 100, 2, 50000, 1, 0, 0, 0, 0));
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);
    drain();

    // random phases, extremes and saturating writes first, mostly small lists
    for (int ph = 0; n_items < 2000; ph++) begin
      if (n_items > 1700) quiet = 1'b1;
      case (ph)
        0: begin
          write_cfg(sdv_pkg::CfgDraftCount, 7'd5);
          write_cfg(sdv_pkg::CfgListLength, 7'd64);
        end
        1: begin
          write_cfg(sdv_pkg::CfgDraftCount, 7'd0);
          write_cfg(sdv_pkg::CfgListLength, 7'd0);
        end
        2: begin
          write_cfg(sdv_pkg::CfgDraftCount, 7'h7f);
          write_cfg(sdv_pkg::CfgListLength, 7'h7f);
        end
        3: begin
          write_cfg(sdv_pkg::CfgDraftCount, 7'd1);
          write_cfg(sdv_pkg::CfgListLength, 7'd2);
        end
        default: begin
          write_cfg(sdv_pkg::CfgDraftCount, 7'($urandom_range(0, 127)));
          write_cfg(sdv_pkg::CfgListLength, ($urandom_range(0, 30) == 0) ?
                    7'($urandom_range(0, 127)) : 7'($urandom_range(1, 6)));
        end
      endcase
      repeat ((n_list > 16) ? 1 : $urandom_range(2, 6)) send_chain();
      drain();
    end

    in_valid_i <= 1'b0;
    wait_cnt = 0;
    while (verdict_q.size() != 0 && wait_cnt < 200000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (50) @(negedge clk_i);
    if (verdict_q.size() != 0) n_err++;
    $display("covered %0d beats, %0d verdicts; accept counts 0..5: %0d %0d %0d %0d %0d %0d",
             n_items, n_verdicts, n_accept_hist[0], n_accept_hist[1], n_accept_hist[2],
             n_accept_hist[3], n_accept_hist[4], n_accept_hist[5]);
    $display("mismatches counted: %0d", n_err);
    if (n_err == 0) begin
      $display("tb_speculative_draft_verify_top_k_unit: done, clean");
    end else begin
      $display("tb_speculative_draft_verify_top_k_unit: done, errors");
    end
    $finish;
  end

endmodule
